// ===== rtl/core/lot_pkg.sv =====
// Shared types and constants for the layer-ordered entry table.
// Holds table sizing, action and status codes, controller states and
// the command/status structs passed between controller and datapath.
`timescale 1ns / 1ps

package lot_pkg;

    // Table sizing
    localparam int MAX_ENTRIES = 32;
    localparam int ID_BITS     = 16;
    localparam int LAYER_W     = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = ID_BITS + LAYER_W;

    // Fixed field widths of the channels
    localparam int ACTION_W    = 2;
    localparam int EXT_ID_W    = 16;
    localparam int STATUS_W    = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_LIST   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_ENTRY     = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        t_action               action;
        logic [EXT_ID_W-1:0]   entity_id;
        logic [LAYER_W-1:0]    layer;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [EXT_ID_W-1:0]   entry_id;
        logic [LAYER_W-1:0]    entry_layer;
        logic                  last;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CLEAR,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_LIST_CHK,
        S_SO_CHK,
        S_SO_KEY,
        S_SO_PCHK,
        S_SO_CMP,
        S_LS_CHK,
        S_LS_OUT,
        S_EMIT
    } t_state;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,        // latch input item, reset scan index
        OP_ADD,         // append latched entry, mark unsorted
        OP_CLEAR,       // empty the table
        OP_RD_I,        // read entry at scan index
        OP_INC_I,       // advance scan index
        OP_RD_I1,       // read entry after scan index
        OP_WR_I_INC,    // write read data at scan index, advance
        OP_DEC_CNT,     // drop one entry from the count
        OP_SORT_INIT,   // start insertion sort at entry one
        OP_KEY,         // latch sort key and insert position
        OP_WR_KEY,      // write key at insert position, next key
        OP_RD_POS1,     // read entry before insert position
        OP_WR_SHIFT,    // move read entry up, step position down
        OP_SORT_DONE,   // mark sorted, restart scan index
        OP_EMIT,        // put a single status result
        OP_EMIT_ENTRY   // put a listed entry, advance
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status st;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic full;
        logic empty;
        logic needs_sort;
        logic i_end;
        logic nxt_end;
        logic match;
        logic pos_zero;
        logic greater;
    } t_dp_status;

endpackage

// ===== rtl/core/lot_in_if.sv =====
// Input channel of the layer-ordered entry table: valid/ready plus item.
// Depends on lot_pkg for the item type.
`timescale 1ns / 1ps

interface lot_in_if;
    import lot_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lot_out_if.sv =====
// Result channel of the layer-ordered entry table: valid/ready plus item.
// Depends on lot_pkg for the item type.
`timescale 1ns / 1ps

interface lot_out_if;
    import lot_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lot_dp.sv =====
// Datapath of the layer-ordered entry table: entry memory, count, indexes,
// sort key and result register. Driven by micro-ops from lot_ctrl; uses lot_pkg.
`timescale 1ns / 1ps

module lot_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lot_pkg::t_dp_cmd   i_cmd,
    input  lot_pkg::t_in_item  i_in_data,
    input  logic               i_out_ready,
    output lot_pkg::t_dp_status o_status,
    output logic               o_out_valid,
    output lot_pkg::t_out_item o_out_data
);
    import lot_pkg::*;

    // Entry memory: {id, layer}
    logic [ENTRY_W-1:0] r_mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_needs_sort, n_needs_sort;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [ENTRY_W-1:0] r_key, n_key;
    logic [ID_BITS-1:0] r_cmd_id, n_cmd_id;
    logic [LAYER_W-1:0] r_cmd_layer, n_cmd_layer;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   i_plus1;
    logic [CNT_W-1:0]   pos_minus1;
    logic [ID_BITS-1:0] rd_id;
    logic [LAYER_W-1:0] rd_layer;
    logic [LAYER_W-1:0] key_layer;

    assign i_plus1    = r_i + CNT_W'(1);
    assign pos_minus1 = r_pos - CNT_W'(1);
    assign rd_id      = r_rd_data[ENTRY_W-1:LAYER_W];
    assign rd_layer   = r_rd_data[LAYER_W-1:0];
    assign key_layer  = r_key[LAYER_W-1:0];

    // Status toward the controller
    always_comb begin
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.full       = (r_count == CNT_W'(MAX_ENTRIES));
        o_status.empty      = (r_count == '0);
        o_status.needs_sort = r_needs_sort;
        o_status.i_end      = (r_i >= r_count);
        o_status.nxt_end    = (i_plus1 >= r_count);
        o_status.match      = (rd_id == r_cmd_id);
        o_status.pos_zero   = (r_pos == '0);
        o_status.greater    = (rd_layer > key_layer);
    end

    // Decode memory ports and next register values
    always_comb begin
        wr_en       = 1'b0;
        wr_addr     = r_i[IDX_W-1:0];
        wr_data     = r_rd_data;
        rd_en       = 1'b0;
        rd_addr     = r_i[IDX_W-1:0];
        n_count     = r_count;
        n_needs_sort = r_needs_sort;
        n_i         = r_i;
        n_pos       = r_pos;
        n_key       = r_key;
        n_cmd_id    = r_cmd_id;
        n_cmd_layer = r_cmd_layer;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (i_cmd.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                n_cmd_id    = i_in_data.entity_id[ID_BITS-1:0];
                n_cmd_layer = i_in_data.layer;
                n_i         = '0;
            end
            OP_ADD: begin
                wr_en        = 1'b1;
                wr_addr      = r_count[IDX_W-1:0];
                wr_data      = {r_cmd_id, r_cmd_layer};
                n_count      = r_count + CNT_W'(1);
                n_needs_sort = 1'b1;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_RD_I: begin
                rd_en = 1'b1;
            end
            OP_INC_I: begin
                n_i = i_plus1;
            end
            OP_RD_I1: begin
                rd_en   = 1'b1;
                rd_addr = i_plus1[IDX_W-1:0];
            end
            OP_WR_I_INC: begin
                wr_en = 1'b1;
                n_i   = i_plus1;
            end
            OP_DEC_CNT: begin
                n_count = r_count - CNT_W'(1);
            end
            OP_SORT_INIT: begin
                n_i = CNT_W'(1);
            end
            OP_KEY: begin
                n_key = r_rd_data;
                n_pos = r_i;
            end
            OP_WR_KEY: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IDX_W-1:0];
                wr_data = r_key;
                n_i     = i_plus1;
            end
            OP_RD_POS1: begin
                rd_en   = 1'b1;
                rd_addr = pos_minus1[IDX_W-1:0];
            end
            OP_WR_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IDX_W-1:0];
                n_pos   = pos_minus1;
            end
            OP_SORT_DONE: begin
                n_needs_sort = 1'b0;
                n_i          = '0;
            end
            OP_EMIT: begin
                n_out_valid       = 1'b1;
                n_out.status      = i_cmd.st;
                n_out.entry_id    = '0;
                n_out.entry_layer = '0;
                n_out.last        = 1'b1;
            end
            OP_EMIT_ENTRY: begin
                n_out_valid       = 1'b1;
                n_out.status      = ST_ENTRY;
                n_out.entry_id    = EXT_ID_W'(rd_id);
                n_out.entry_layer = rd_layer;
                n_out.last        = (i_plus1 >= r_count);
                n_i               = i_plus1;
            end
            default: begin
            end
        endcase
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_needs_sort <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_needs_sort <= n_needs_sort;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_cmd_id    <= n_cmd_id;
        r_cmd_layer <= n_cmd_layer;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/lot_ctrl.sv =====
// Controller of the layer-ordered entry table: sequences add, remove,
// clear, insertion sort and listing as datapath micro-ops. Uses lot_pkg.
`timescale 1ns / 1ps

module lot_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lot_pkg::t_action    i_in_action,
    input  lot_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output lot_pkg::t_dp_cmd    o_cmd
);
    import lot_pkg::*;

    t_state  r_state, n_state;
    t_status r_emit_st, n_emit_st;

    // State and pending status register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_emit_st <= ST_DONE;
        end else begin
            r_state   <= n_state;
            r_emit_st <= n_emit_st;
        end
    end

    // Next state and micro-op
    always_comb begin
        n_state    = r_state;
        n_emit_st  = r_emit_st;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NOP;
        o_cmd.st   = r_emit_st;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    unique case (i_in_action)
                        ACT_ADD:    n_state = S_ADD;
                        ACT_REMOVE: n_state = S_RM_RD;
                        ACT_CLEAR:  n_state = S_CLEAR;
                        ACT_LIST:   n_state = S_LIST_CHK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                n_state = S_EMIT;
                if (i_status.full) begin
                    n_emit_st = ST_FULL;
                end else begin
                    o_cmd.op  = OP_ADD;
                    n_emit_st = ST_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.op  = OP_CLEAR;
                n_emit_st = ST_DONE;
                n_state   = S_EMIT;
            end
            // Scan for the first matching id
            S_RM_RD: begin
                if (i_status.i_end) begin
                    n_emit_st = ST_NOT_FOUND;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (i_status.match) begin
                    n_state = S_SH_RD;
                end else begin
                    o_cmd.op = OP_INC_I;
                    n_state  = S_RM_RD;
                end
            end
            // Close the gap one entry at a time
            S_SH_RD: begin
                if (i_status.nxt_end) begin
                    o_cmd.op  = OP_DEC_CNT;
                    n_emit_st = ST_DONE;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.op = OP_RD_I1;
                    n_state  = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.op = OP_WR_I_INC;
                n_state  = S_SH_RD;
            end
            S_LIST_CHK: begin
                if (i_status.needs_sort) begin
                    o_cmd.op = OP_SORT_INIT;
                    n_state  = S_SO_CHK;
                end else begin
                    n_state = S_LS_CHK;
                end
            end
            // Insertion sort: take key, move larger layers up
            S_SO_CHK: begin
                if (i_status.i_end) begin
                    o_cmd.op = OP_SORT_DONE;
                    n_state  = S_LS_CHK;
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_SO_KEY;
                end
            end
            S_SO_KEY: begin
                o_cmd.op = OP_KEY;
                n_state  = S_SO_PCHK;
            end
            S_SO_PCHK: begin
                if (i_status.pos_zero) begin
                    o_cmd.op = OP_WR_KEY;
                    n_state  = S_SO_CHK;
                end else begin
                    o_cmd.op = OP_RD_POS1;
                    n_state  = S_SO_CMP;
                end
            end
            S_SO_CMP: begin
                if (i_status.greater) begin
                    o_cmd.op = OP_WR_SHIFT;
                    n_state  = S_SO_PCHK;
                end else begin
                    o_cmd.op = OP_WR_KEY;
                    n_state  = S_SO_CHK;
                end
            end
            // List entries in table order
            S_LS_CHK: begin
                if (i_status.i_end) begin
                    if (i_status.empty) begin
                        n_emit_st = ST_EMPTY;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_LS_OUT;
                end
            end
            S_LS_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT_ENTRY;
                    n_state  = i_status.nxt_end ? S_IDLE : S_LS_CHK;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/layer_ordered_entry_table_top.sv =====
// Layer-ordered entry table: add, clear, remove and list, one item at a time.
// Remove scans for the id, then shifts the later entries down one by one.
// List first runs an insertion sort if an add left the table unsorted, then
// emits one result per entry, waiting while the output register is not free.
// Reset (synchronous, active low) empties the table and clears the sort flag;
// memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module layer_ordered_entry_table_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lot_in_if.sink    i_in,
    lot_out_if.source o_out
);
    import lot_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // Sequence the micro-ops
    lot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.data.action),
        .i_status    (dp_status),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    // Hold the table and the result register
    lot_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in.data),
        .i_out_ready (o_out.ready),
        .o_status    (dp_status),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

endmodule
